[rtl/core/mncc_pkg.sv]
// Shared types and constants for the masked NCC combine block.
// No dependencies; every module of the block imports this package.
package mncc_pkg;

    localparam int MAX_OVERLAP    = 65536;
    localparam int CORR_FRAC_BITS = 14;

    localparam int OVL_W  = 17;
    localparam int SUM_W  = 24;
    localparam int SQ_W   = 32;
    localparam int CORR_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAG_W  = 48;               // |P|, A, B, tol*s
    localparam int HALF_W = MAG_W / 2;
    localparam int PROD_W = 2 * MAG_W;        // A*B, (tol*s)^2, P^2
    localparam int RSH    = 2 * CORR_FRAC_BITS + 2;
    localparam int EW     = PROD_W + RSH + 8; // residual / trial term width
    localparam int Q_W    = CORR_FRAC_BITS + 1;
    localparam int BIT_W  = $clog2(Q_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_OVERLAP = 2'd0,
        CFG_DENOM_TOL   = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [OVL_W-1:0] overlap_count;
        logic [SUM_W-1:0] fixed_window_sum;
        logic [SUM_W-1:0] moving_window_sum;
        logic [SQ_W-1:0]  fixed_square_sum;
        logic [SQ_W-1:0]  moving_square_sum;
        logic [SQ_W-1:0]  cross_sum;
    } t_in_beat;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [OVL_W-1:0]         overlap_out;
        logic                     score_valid;
    } t_out_beat;

    typedef struct packed {
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [MAG_W-1:0] l;
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             below;
        logic [OVL_W-1:0] ovl;
    } t_front;

    typedef struct packed {
        logic [PROD_W-1:0] ab;
        logic [PROD_W-1:0] ll;
        logic [PROD_W-1:0] mm;
        logic              neg;
        logic              below;
        logic [OVL_W-1:0]  ovl;
    } t_prod;

    typedef struct packed {
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] t;
        logic [PROD_W-1:0]    ab;
        logic [Q_W-1:0]       q;
        logic                 neg;
        logic                 ok;
        logic [OVL_W-1:0]     ovl;
    } t_root;

endpackage

[rtl/core/masked_ncc_combine_unit.sv]
// Top level of the masked NCC combine block: config registers, root-search
// setup, the per-bit search chain and the output register. Uses mncc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_beat): one beat per output
//   position carrying overlap count and the five masked window sums.
//   Output channel (o_out_valid / i_out_ready / o_out_beat): one beat per
//   input beat, in order: Q2.14 correlation, overlap passed through, and
//   score_valid.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; index 0 = min_overlap, 1 = denom_tolerance, others ignored.
//   Write it only while the pipeline is empty.
// Pipeline: 2 product/subtract stages, 2 wide-multiply stages, 1 setup
//   stage, 15 bit-search stages, 1 output stage.
// Throughput: one beat per cycle unless the output stalls; the 15-stage
//   bit search sets the depth.
// Stall: every stage carries its own valid bit and advances whenever the
//   next one is empty or moving, so bubbles collapse and input keeps being
//   taken until all stages hold data and the output is stalled.
// Reset: synchronous, active low; clears all stage valid bits and both
//   config registers to zero.
module masked_ncc_combine_unit
    import mncc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [OVL_W-1:0]      r_min_overlap;
    logic [CFG_DATA_W-1:0] r_denom_tol;

    logic   w_fr_v, w_fr_rdy;
    t_front w_fr_d;
    logic   w_mu_v, w_mu_rdy;
    t_prod  w_mu_d;

    logic   r_ini_v;
    t_root  r_ini;
    logic   w_ini_adv;

    logic   w_v   [Q_W+1];
    logic   w_rdy [Q_W+1];
    t_root  w_root[Q_W+1];

    logic   r_out_v;
    t_out_beat r_out;
    logic   w_out_adv;
    logic [Q_W-1:0] w_q_sat;
    t_root  w_last;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_overlap <= '0;
            r_denom_tol   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_OVERLAP: r_min_overlap <= i_cfg_data[OVL_W-1:0];
                CFG_DENOM_TOL:   r_denom_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- products and variances ----------------
    mncc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_beat        (i_in_beat),
        .i_min_overlap (r_min_overlap),
        .i_denom_tol   (r_denom_tol),
        .o_valid       (w_fr_v),
        .i_ready       (w_fr_rdy),
        .o_data        (w_fr_d)
    );

    mncc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_v),
        .o_ready (w_fr_rdy),
        .i_data  (w_fr_d),
        .o_valid (w_mu_v),
        .i_ready (w_mu_rdy),
        .o_data  (w_mu_d)
    );

    // ---------------- search setup ----------------
    // tolerance test A*B > (tol*s)^2; residual starts at P^2*2^(2F+2) - A*B
    // (q = 0 gives (2q-1)^2 = 1), running term T = -A*B
    assign w_ini_adv = !r_ini_v || w_rdy[0];
    assign w_mu_rdy  = w_ini_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ini_v <= 1'b0;
        end else if (w_ini_adv) begin
            r_ini_v <= w_mu_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ini_adv) begin
            r_ini.e   <= $signed((EW'(w_mu_d.mm) << RSH) - EW'(w_mu_d.ab));
            r_ini.t   <= $signed(EW'(0) - EW'(w_mu_d.ab));
            r_ini.ab  <= w_mu_d.ab;
            r_ini.q   <= '0;
            r_ini.neg <= w_mu_d.neg;
            r_ini.ok  <= !w_mu_d.below && (w_mu_d.ab > w_mu_d.ll);
            r_ini.ovl <= w_mu_d.ovl;
        end
    end

    assign w_v[0]    = r_ini_v;
    assign w_root[0] = r_ini;

    // ---------------- bit search, MSB first ----------------
    for (genvar g = 0; g < Q_W; g++) begin : g_step
        mncc_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (BIT_W'(Q_W - 1 - g)),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_root[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_root[g+1])
        );
    end

    // ---------------- output register ----------------
    assign w_last    = w_root[Q_W];
    assign w_out_adv = !r_out_v || i_out_ready;
    assign w_rdy[Q_W] = w_out_adv;

    // anything at or above one saturates to exactly 2^F
    assign w_q_sat = w_last.q[Q_W-1] ? (Q_W'(1) << CORR_FRAC_BITS) : w_last.q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_adv) begin
            r_out_v <= w_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out.overlap_out <= w_last.ovl;
            r_out.score_valid <= w_last.ok;
            if (!w_last.ok) begin
                r_out.correlation <= '0;
            end else if (w_last.neg) begin
                r_out.correlation <= CORR_W'(-$signed({1'b0, w_q_sat}));
            end else begin
                r_out.correlation <= CORR_W'(w_q_sat);
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out;

endmodule

[rtl/core/mncc_front.sv]
// Front end: window-sum products, then numerator and clamped variances.
// Two register stages; depends on mncc_pkg.
module mncc_front
    import mncc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_beat             i_beat,
    input  logic [OVL_W-1:0]     i_min_overlap,
    input  logic [CFG_DATA_W-1:0] i_denom_tol,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_front               o_data
);

    logic [OVL_W-1:0] w_ne;
    logic [OVL_W-1:0] w_s;
    logic             w_zero;

    logic             r1_v;
    logic [MAG_W-1:0] r1_pc, r1_pfm, r1_pa, r1_pff, r1_pb, r1_pmm, r1_pl;
    logic             r1_below;
    logic [OVL_W-1:0] r1_ovl;

    logic             r2_v;
    t_front           r2_d;

    logic signed [MAG_W:0] w_p;
    logic             w_adv1, w_adv2;

    // overlap above the maximum is clamped; zero overlap drops the mean terms
    assign w_ne   = (i_beat.overlap_count > OVL_W'(MAX_OVERLAP)) ?
                    OVL_W'(MAX_OVERLAP) : i_beat.overlap_count;
    assign w_zero = (w_ne == '0);
    assign w_s    = w_zero ? OVL_W'(1) : w_ne;

    assign w_adv2  = !r2_v || i_ready;
    assign w_adv1  = !r1_v || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r2_v;
    assign o_data  = r2_d;

    assign w_p = $signed({1'b0, r1_pc}) - $signed({1'b0, r1_pfm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (w_adv1) r1_v <= i_valid;
            if (w_adv2) r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_pc    <= MAG_W'(w_s) * MAG_W'(i_beat.cross_sum);
            r1_pfm   <= w_zero ? '0 :
                        MAG_W'(i_beat.fixed_window_sum) * MAG_W'(i_beat.moving_window_sum);
            r1_pa    <= MAG_W'(w_s) * MAG_W'(i_beat.fixed_square_sum);
            r1_pff   <= w_zero ? '0 :
                        MAG_W'(i_beat.fixed_window_sum) * MAG_W'(i_beat.fixed_window_sum);
            r1_pb    <= MAG_W'(w_s) * MAG_W'(i_beat.moving_square_sum);
            r1_pmm   <= w_zero ? '0 :
                        MAG_W'(i_beat.moving_window_sum) * MAG_W'(i_beat.moving_window_sum);
            r1_pl    <= MAG_W'(w_s) * MAG_W'(i_denom_tol);
            r1_below <= (i_beat.overlap_count < i_min_overlap);
            r1_ovl   <= i_beat.overlap_count;
        end
        if (w_adv2) begin
            r2_d.a     <= (r1_pa >= r1_pff) ? (r1_pa - r1_pff) : '0;
            r2_d.b     <= (r1_pb >= r1_pmm) ? (r1_pb - r1_pmm) : '0;
            r2_d.l     <= r1_pl;
            r2_d.neg   <= w_p[MAG_W];
            r2_d.mag   <= w_p[MAG_W] ? MAG_W'(-w_p) : MAG_W'(w_p);
            r2_d.below <= r1_below;
            r2_d.ovl   <= r1_ovl;
        end
    end

endmodule

[rtl/core/mncc_mul.sv]
// Wide products A*B, (tol*s)^2 and |P|^2 from half-width partial products.
// Two register stages; depends on mncc_pkg.
module mncc_mul
    import mncc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_prod  o_data
);

    // partials per product: [0] lo*lo, [1] lo*hi, [2] hi*lo, [3] hi*hi
    logic [MAG_W-1:0] r_pab [4];
    logic [MAG_W-1:0] r_pll [4];
    logic [MAG_W-1:0] r_pmm [4];
    logic             r1_v;
    logic             r1_neg, r1_below;
    logic [OVL_W-1:0] r1_ovl;

    logic             r2_v;
    t_prod            r2_d;
    logic             w_adv1, w_adv2;

    function automatic logic [MAG_W-1:0] pp(input logic [MAG_W-1:0] x,
                                            input logic [MAG_W-1:0] y,
                                            input logic hx, input logic hy);
        logic [HALF_W-1:0] xs, ys;
        begin
            xs = hx ? x[MAG_W-1:HALF_W] : x[HALF_W-1:0];
            ys = hy ? y[MAG_W-1:HALF_W] : y[HALF_W-1:0];
            pp = MAG_W'(xs) * MAG_W'(ys);
        end
    endfunction

    function automatic logic [PROD_W-1:0] join4(input logic [MAG_W-1:0] p0,
                                                input logic [MAG_W-1:0] p1,
                                                input logic [MAG_W-1:0] p2,
                                                input logic [MAG_W-1:0] p3);
        begin
            join4 = PROD_W'(p0) + (PROD_W'(p1) << HALF_W) + (PROD_W'(p2) << HALF_W)
                  + (PROD_W'(p3) << MAG_W);
        end
    endfunction

    assign w_adv2  = !r2_v || i_ready;
    assign w_adv1  = !r1_v || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r2_v;
    assign o_data  = r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (w_adv1) r1_v <= i_valid;
            if (w_adv2) r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            for (int k = 0; k < 4; k++) begin
                r_pab[k] <= pp(i_data.a, i_data.b, k[1], k[0]);
                r_pll[k] <= pp(i_data.l, i_data.l, k[1], k[0]);
                r_pmm[k] <= pp(i_data.mag, i_data.mag, k[1], k[0]);
            end
            r1_neg   <= i_data.neg;
            r1_below <= i_data.below;
            r1_ovl   <= i_data.ovl;
        end
        if (w_adv2) begin
            r2_d.ab    <= join4(r_pab[0], r_pab[1], r_pab[2], r_pab[3]);
            r2_d.ll    <= join4(r_pll[0], r_pll[1], r_pll[2], r_pll[3]);
            r2_d.mm    <= join4(r_pmm[0], r_pmm[1], r_pmm[2], r_pmm[3]);
            r2_d.neg   <= r1_neg;
            r2_d.below <= r1_below;
            r2_d.ovl   <= r1_ovl;
        end
    end

endmodule

[rtl/core/mncc_root_step.sv]
// One bit of the ratio search: tries setting bit i_bit of q, keeps it if the
// residual stays non-negative. One register stage; depends on mncc_pkg.
module mncc_root_step
    import mncc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BIT_W-1:0] i_bit,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_root            i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_root            o_data
);

    logic [5:0]           w_sh_t, w_sh_ab, w_sh_up;
    logic signed [EW-1:0] w_x, w_try;
    logic                 w_take;
    logic                 r_v;
    t_root                r_d;
    t_root                n_d;
    logic                 w_adv;

    // (2q'-1)^2*AB = (2q-1)^2*AB + T*2^(k+2) + AB*2^(2k+2), T = (2q-1)*AB
    assign w_sh_t  = 6'(i_bit) + 6'd2;
    assign w_sh_ab = {1'b0, i_bit, 1'b0} + 6'd2;
    assign w_sh_up = 6'(i_bit) + 6'd1;
    assign w_x     = (i_data.t <<< w_sh_t) + $signed(EW'(i_data.ab) << w_sh_ab);
    assign w_try   = i_data.e - w_x;
    assign w_take  = !w_try[EW-1];

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        n_d = i_data;
        if (w_take) begin
            n_d.e = w_try;
            n_d.t = i_data.t + $signed(EW'(i_data.ab) << w_sh_up);
            n_d.q = i_data.q | (Q_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d <= n_d;
        end
    end

endmodule

[rtl/core/mncc_checker.sv]
// Port-level checks for masked_ncc_combine_unit, attached by bind.
// Depends on mncc_pkg and the top level's port list.
module mncc_checker
    import mncc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_beat))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // no score means a zero correlation
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.score_valid |-> o_out_beat.correlation == 0)
        else $error("nonzero correlation without score");

    // correlation stays within minus one to one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.correlation <= 16'sd16384) &&
                        (o_out_beat.correlation >= -16'sd16384))
        else $error("correlation out of range");

    // input backpressure only when the pipe is full behind a stalled output
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output moves");

endmodule

bind masked_ncc_combine_unit mncc_checker u_mncc_checker (.*);
